FILE: hdl/wtsg_pkg.sv
// Shared constants, types and the sine threshold table for the waveform sample generator.
package wtsg_pkg;

    // Table and phase sizing
    localparam int MAX_TABLE  = 512;
    localparam int PHASE_BITS = 16;

    // Fixed field widths
    localparam int IDX_W      = 9;
    localparam int SMP_W      = 8;
    localparam int SHAPE_W    = 2;
    localparam int PERIOD_W   = 20;
    localparam int OFFSET_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Derived widths
    localparam int LEN_W         = $clog2(MAX_TABLE + 1);
    localparam int CMP_W         = (IDX_W > LEN_W) ? IDX_W : LEN_W;
    localparam int DIV_PER_STAGE = 4;
    localparam int DIV_STAGES    = (PHASE_BITS + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
    localparam int THR_W         = PHASE_BITS - 1;
    localparam int LVL_W         = SMP_W - 1;
    localparam int LVL_N         = 2 ** LVL_W;
    localparam int MUL_W         = PHASE_BITS + SMP_W;

    localparam logic [PHASE_BITS-1:0] PH_HALF    = PHASE_BITS'(2 ** (PHASE_BITS - 1));
    localparam logic [PHASE_BITS-1:0] PH_QUARTER = PHASE_BITS'(2 ** (PHASE_BITS - 2));

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_WAVE_SHAPE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_US    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_OFFSET = CFG_IDX_W'(2);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);

    typedef enum logic [SHAPE_W-1:0] {
        SHAPE_SINE     = 2'd0,
        SHAPE_SQUARE   = 2'd1,
        SHAPE_TRIANGLE = 2'd2,
        SHAPE_SAW      = 2'd3
    } shape_t;

    // Settings seen by the datapath; the user must keep them static while items are in flight (not enforced)
    typedef struct packed {
        shape_t                shape;
        logic [LEN_W-1:0]      len;
        logic [PHASE_BITS-1:0] off;
    } cfg_t;

    // Item inside the divider
    typedef struct packed {
        logic                  ok;
        logic                  last;
        logic [LEN_W-1:0]      rem;
        logic [PHASE_BITS-1:0] quo;
    } div_item_t;

    // Item after the offset subtract
    typedef struct packed {
        logic                  ok;
        logic                  last;
        logic [PHASE_BITS-1:0] p;
    } phase_item_t;

    // Item through the sine search
    typedef struct packed {
        logic             ok;
        logic             last;
        logic             is_sine;
        logic             neg;
        logic             rnz;
        logic [THR_W-1:0] r;
        logic [SMP_W-1:0] smp;
        logic [LVL_W-1:0] level;
    } wave_item_t;

    // Sine thresholds: entry k is the first quarter-wave phase at which
    // 127.5*sin reaches k. Entry 0 is never looked up.
    localparam real PI         = 3.14159265358979323846;
    localparam real SIN_SCALE  = 255.0 / 2.0;
    localparam real INV_SCALE  = 1.0 / SIN_SCALE;
    localparam real PH_PER_RAD = (2.0 ** PHASE_BITS) / (2.0 * PI);

    typedef logic [LVL_N-1:0][THR_W-1:0] thr_tab_t;

    function automatic thr_tab_t build_sin_thr();
        thr_tab_t tab;
        real      x;
        tab = '0;
        for (int k = 1; k < LVL_N; k++) begin
            x = $asin(real'(k) * INV_SCALE) * PH_PER_RAD;
            tab[k] = THR_W'(longint'($ceil(x)));
        end
        return tab;
    endfunction

    localparam thr_tab_t SIN_THR = build_sin_thr();

endpackage

FILE: hdl/waveform_table_sample_generator.sv
// Top level of the waveform table sample generator: settings, datapath chain, result register.
// Registered stages from accept to result: input check, DIV_STAGES divider stages (4 at the defaults,
// of 4 quotient bits each), phase and fold, LVL_W search stages (7 at the defaults), output.
// Throughput: one item per cycle while m_ready keeps the result moving; every stage has its own valid bit
// and takes a new item whenever it is empty or its successor moves, so bubbles close up under output stall.
// Reset (aresetn low at a clock edge): all valid bits clear, settings return to sine,
// period 1000 us and zero phase offset.
module waveform_table_sample_generator (
    input  logic                             aclk,
    input  logic                             aresetn,

    // Settings write port
    input  logic                             cfg_wr_en,
    input  logic [wtsg_pkg::CFG_IDX_W-1:0]   cfg_wr_idx,
    input  logic [wtsg_pkg::CFG_DATA_W-1:0]  cfg_wr_data,

    // Index in
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [wtsg_pkg::IDX_W-1:0]       s_index,

    // Sample out
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [wtsg_pkg::SMP_W-1:0]       m_sample,
    output logic                             m_last,
    output logic                             m_valid_res
);
    import wtsg_pkg::*;

    // ------------------------------------------------------------------
    // Settings registers
    // ------------------------------------------------------------------
    shape_t                shape_reg;
    logic [PERIOD_W-1:0]   period_reg;
    logic [OFFSET_W-1:0]   offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shape_reg  <= SHAPE_SINE;
            period_reg <= PERIOD_RESET;
            offset_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_idx)
                REG_WAVE_SHAPE:   shape_reg  <= shape_t'(cfg_wr_data[SHAPE_W-1:0]);
                REG_PERIOD_US:    period_reg <= cfg_wr_data[PERIOD_W-1:0];
                REG_PHASE_OFFSET: offset_reg <= cfg_wr_data[OFFSET_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // Table length: min(period, MAX_TABLE), forced even.
    // Offset is rescaled from 1/65536 turn to PHASE_BITS: off = offset * 2^PHASE_BITS >> 16.
    cfg_t                           cfg;
    logic [LEN_W-1:0]               len_raw;
    logic [OFFSET_W+PHASE_BITS-1:0] off_wide;

    always_comb begin
        len_raw  = (period_reg >= PERIOD_W'(MAX_TABLE)) ? LEN_W'(MAX_TABLE)
                                                        : period_reg[LEN_W-1:0];
        off_wide = {offset_reg, {PHASE_BITS{1'b0}}};

        cfg.shape = shape_reg;
        cfg.len   = {len_raw[LEN_W-1:1], 1'b0};
        cfg.off   = off_wide[OFFSET_W+PHASE_BITS-1:OFFSET_W];
    end

    // ------------------------------------------------------------------
    // Datapath chain: divide -> phase/fold -> sine search
    // ------------------------------------------------------------------
    logic        div_valid;
    logic        div_ready;
    div_item_t   div_item;

    logic        shp_valid;
    logic        shp_ready;
    wave_item_t  shp_item;

    logic        srch_valid;
    logic        srch_ready;
    wave_item_t  srch_item;

    wtsg_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_len   (cfg.len),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_idx    (s_index),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_item  (div_item)
    );

    wtsg_shape u_shape (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .in_item   (div_item),
        .out_valid (shp_valid),
        .out_ready (shp_ready),
        .out_item  (shp_item)
    );

    wtsg_search u_search (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (shp_valid),
        .in_ready  (shp_ready),
        .in_item   (shp_item),
        .out_valid (srch_valid),
        .out_ready (srch_ready),
        .out_item  (srch_item)
    );

    // ------------------------------------------------------------------
    // Result register
    // Sine: level counts thresholds passed, so the positive half is
    // 128 + floor(127.5*s) and the negative half 128 - ceil(127.5*s);
    // the ceil adds one except at a zero sine.
    // ------------------------------------------------------------------
    logic               m_valid_reg;
    logic [SMP_W-1:0]   sample_reg;
    logic               last_reg;
    logic               valid_res_reg;
    logic               out_rdy;
    logic [SMP_W-1:0]   sample_next;
    logic [SMP_W-1:0]   sine_pos;
    logic [SMP_W-1:0]   sine_neg;

    assign out_rdy    = !m_valid_reg || m_ready;
    assign srch_ready = out_rdy;

    always_comb begin
        sine_pos = SMP_W'(LVL_N) + SMP_W'(srch_item.level);
        sine_neg = SMP_W'(LVL_N) - SMP_W'(srch_item.level) - SMP_W'(srch_item.rnz);
        if (!srch_item.ok) begin
            sample_next = '0;
        end else if (srch_item.is_sine) begin
            sample_next = srch_item.neg ? sine_neg : sine_pos;
        end else begin
            sample_next = srch_item.smp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_rdy) begin
            m_valid_reg <= srch_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_rdy && srch_valid) begin
            sample_reg    <= sample_next;
            last_reg      <= srch_item.ok && srch_item.last;
            valid_res_reg <= srch_item.ok;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_sample    = sample_reg;
    assign m_last      = last_reg;
    assign m_valid_res = valid_res_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Input can only be held off when every stage is full and the result waits.
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("s_ready low while the result register can move");

    // An invalid item carries a zero sample and no last flag.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_valid_res) |-> (m_sample == '0 && !m_last))
        else $error("invalid item with nonzero sample or last flag");

    // Last only on valid items.
    a_last_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last) |-> m_valid_res)
        else $error("last flag on an invalid item");

    // Reset empties the result register.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

FILE: hdl/wtsg_div.sv
// Input stage and pipelined restoring divider forming index * 2^PHASE_BITS / len.
module wtsg_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [wtsg_pkg::LEN_W-1:0]    cfg_len,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [wtsg_pkg::IDX_W-1:0]    in_idx,
    output logic                          out_valid,
    input  logic                          out_ready,
    output wtsg_pkg::div_item_t           out_item
);
    import wtsg_pkg::*;

    localparam int NST = DIV_STAGES + 1;

    div_item_t  st_reg [NST];
    logic       v_reg  [NST];
    logic [NST:0] rdy;

    assign rdy[NST]  = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NST-1];
    assign out_item  = st_reg[NST-1];

    for (genvar i = 0; i < NST; i++) begin : g_stage
        div_item_t st_next;
        logic      src_v;

        assign rdy[i] = !v_reg[i] || rdy[i+1];

        if (i == 0) begin : g_entry
            logic [CMP_W-1:0] idx_c;
            logic [CMP_W-1:0] len_c;

            assign src_v = in_valid;
            assign idx_c = CMP_W'(in_idx);
            assign len_c = CMP_W'(cfg_len);

            always_comb begin
                st_next.ok   = (len_c != '0) && (idx_c < len_c);
                st_next.last = st_next.ok && (idx_c == len_c - CMP_W'(1));
                st_next.rem  = LEN_W'(in_idx);
                st_next.quo  = '0;
            end
        end else begin : g_step
            assign src_v = v_reg[i-1];

            // DIV_PER_STAGE quotient bits per stage
            always_comb begin
                logic [LEN_W:0] two;
                st_next = st_reg[i-1];
                two     = '0;
                for (int j = 0; j < DIV_PER_STAGE; j++) begin
                    if ((i - 1) * DIV_PER_STAGE + j < PHASE_BITS) begin
                        two = {st_next.rem, 1'b0};
                        if (two >= {1'b0, cfg_len}) begin
                            two = two - {1'b0, cfg_len};
                            st_next.quo = {st_next.quo[PHASE_BITS-2:0], 1'b1};
                        end else begin
                            st_next.quo = {st_next.quo[PHASE_BITS-2:0], 1'b0};
                        end
                        st_next.rem = two[LEN_W-1:0];
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (rdy[i]) begin
                v_reg[i] <= src_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[i] && src_v) begin
                st_reg[i] <= st_next;
            end
        end
    end

endmodule

FILE: hdl/wtsg_shape.sv
// Phase offset subtract, then quarter-wave fold and the square, triangle and sawtooth values.
module wtsg_shape (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  wtsg_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  wtsg_pkg::div_item_t   in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output wtsg_pkg::wave_item_t  out_item
);
    import wtsg_pkg::*;

    phase_item_t ph_reg;
    phase_item_t ph_next;
    logic        ph_v_reg;
    logic        ph_rdy;

    wave_item_t  fd_reg;
    wave_item_t  fd_next;
    logic        fd_v_reg;
    logic        fd_rdy;

    assign fd_rdy    = !fd_v_reg || out_ready;
    assign ph_rdy    = !ph_v_reg || fd_rdy;
    assign in_ready  = ph_rdy;
    assign out_valid = fd_v_reg;
    assign out_item  = fd_reg;

    // Phase wraps modulo one turn
    always_comb begin
        ph_next.ok   = in_item.ok;
        ph_next.last = in_item.last;
        ph_next.p    = in_item.quo - cfg.off;
    end

    always_comb begin
        logic [PHASE_BITS-1:0] p;
        logic [PHASE_BITS-1:0] tq;
        logic [PHASE_BITS-1:0] h;
        logic [PHASE_BITS-1:0] r_full;
        logic [MUL_W-1:0]      tri_sum;
        logic [MUL_W-1:0]      saw_sum;
        p = ph_reg.p;

        tq      = (p <= PH_HALF) ? p : (PHASE_BITS'(0) - p);
        tri_sum = (MUL_W'(tq) << SMP_W) - MUL_W'(tq) + MUL_W'(PH_HALF >> 1);
        saw_sum = (MUL_W'(p) << SMP_W) - MUL_W'(p) + MUL_W'(PH_HALF);

        h      = {1'b0, p[PHASE_BITS-2:0]};
        r_full = (h <= PH_QUARTER) ? h : (PH_HALF - h);

        fd_next.ok      = ph_reg.ok;
        fd_next.last    = ph_reg.last;
        fd_next.is_sine = (cfg.shape == SHAPE_SINE);
        fd_next.neg     = p[PHASE_BITS-1];
        fd_next.rnz     = (r_full != '0);
        fd_next.r       = r_full[THR_W-1:0];
        fd_next.level   = '0;

        case (cfg.shape)
            SHAPE_SQUARE:   fd_next.smp = (p > PH_HALF) ? '1 : '0;
            SHAPE_TRIANGLE: fd_next.smp = tri_sum[PHASE_BITS-1 +: SMP_W];
            SHAPE_SAW:      fd_next.smp = saw_sum[PHASE_BITS +: SMP_W];
            default:        fd_next.smp = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_v_reg <= 1'b0;
            fd_v_reg <= 1'b0;
        end else begin
            if (ph_rdy) begin
                ph_v_reg <= in_valid;
            end
            if (fd_rdy) begin
                fd_v_reg <= ph_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ph_rdy && in_valid) begin
            ph_reg <= ph_next;
        end
        if (fd_rdy && ph_v_reg) begin
            fd_reg <= fd_next;
        end
    end

endmodule

FILE: hdl/wtsg_search.sv
// Pipelined binary search of the sine threshold table, one level bit per stage.
module wtsg_search (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  wtsg_pkg::wave_item_t  in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output wtsg_pkg::wave_item_t  out_item
);
    import wtsg_pkg::*;

    wave_item_t   st_reg [LVL_W];
    logic         v_reg  [LVL_W];
    logic [LVL_W:0] rdy;

    assign rdy[LVL_W] = out_ready;
    assign in_ready   = rdy[0];
    assign out_valid  = v_reg[LVL_W-1];
    assign out_item   = st_reg[LVL_W-1];

    for (genvar s = 0; s < LVL_W; s++) begin : g_stage
        localparam int B = LVL_W - 1 - s;

        wave_item_t       src;
        wave_item_t       st_next;
        logic             src_v;
        logic [LVL_W-1:0] cand;

        assign rdy[s] = !v_reg[s] || rdy[s+1];

        if (s == 0) begin : g_first
            assign src   = in_item;
            assign src_v = in_valid;
        end else begin : g_rest
            assign src   = st_reg[s-1];
            assign src_v = v_reg[s-1];
        end

        always_comb begin
            cand    = src.level;
            cand[B] = 1'b1;
            st_next = src;
            if (src.r >= SIN_THR[cand]) begin
                st_next.level = cand;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (rdy[s]) begin
                v_reg[s] <= src_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (rdy[s] && src_v) begin
                st_reg[s] <= st_next;
            end
        end
    end

endmodule

FILE: tb/waveform_table_sample_generator_tb.sv
// Self-checking testbench for the waveform table sample generator: directed, stall and random items.
`timescale 1ns / 1ps

module waveform_table_sample_generator_tb;
    import wtsg_pkg::*;

    // Q60 fixed point for the sine predictor
    localparam logic [63:0] Q60_UNIT  = 64'h1000_0000_0000_0000;
    localparam logic [63:0] TURN_Q60  = 64'h6487_ED51_10B4_611A;  // 2*pi in Q60
    localparam int          DRAIN_CYC = 40;   // well past the whole pipeline
    localparam int          HOLD_CYC  = 300;  // long output stall for the fill-up test
    localparam int          PHASE_N   = 13;   // random settings phases
    localparam int          PHASE_LEN = 100;  // items per random phase

    typedef struct packed {
        logic [SMP_W-1:0] sample;
        logic             last;
        logic             ok;
    } sample_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_wr_idx;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [IDX_W-1:0]      s_index;
    logic                  m_valid;
    logic                  m_ready;
    logic [SMP_W-1:0]      m_sample;
    logic                  m_last;
    logic                  m_valid_res;

    // Settings as the predictor sees them
    shape_t                cur_shape;
    logic [PERIOD_W-1:0]   cur_period;
    logic [OFFSET_W-1:0]   cur_offset;

    sample_result_t        pending_samples[$];

    // Traffic shaping
    bit src_steady;    // sender never idles while set
    bit sink_steady;   // receiver never idles while set
    bit hold_req;      // receiver starts a long stall of length HOLD_CYC

    int errors;
    int items_sent;
    int results_seen;
    int valid_seen;
    int last_seen;
    int settings_written;

    waveform_table_sample_generator i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_idx  (cfg_wr_idx),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_index     (s_index),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_sample    (m_sample),
        .m_last      (m_last),
        .m_valid_res (m_valid_res)
    );

    // 8 ns clock
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // floor((a*b [+ 2^sh-1]) / 2^sh), kept to 64 bits
    function automatic logic [63:0] q_mul_shift(input logic [63:0] a, input logic [63:0] b,
                                                input int sh, input bit round_up);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        if (round_up)
            prod = prod + ((128'd1 << sh) - 128'd1);
        return 64'(prod >> sh);
    endfunction

    // Sine level for a phase: fold to a quarter wave, Taylor series in Q60,
    // then scale by 127.5 around mid-scale (negative half rounds up in magnitude)
    function automatic logic [SMP_W-1:0] sine_level(input logic [PHASE_BITS-1:0] p);
        logic        neg;
        logic [63:0] h;
        logic [63:0] r;
        logic [63:0] th;
        logic [63:0] z;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] k;
        neg = (p >= PH_HALF);
        h   = neg ? 64'(p - PH_HALF) : 64'(p);
        r   = (h <= 64'(PH_QUARTER)) ? h : 64'(PH_HALF) - h;
        th  = q_mul_shift(TURN_Q60, r << (60 - PHASE_BITS), 60, 1'b0);
        z   = q_mul_shift(th, th, 60, 1'b0);
        t   = Q60_UNIT;
        for (k = 24; k >= 2; k -= 2)
            t = Q60_UNIT - q_mul_shift(z, t, 60, 1'b0) / (k * (k + 64'd1));
        s = q_mul_shift(th, t, 60, 1'b0);
        if (s > Q60_UNIT)
            s = Q60_UNIT;
        if (!neg)
            return SMP_W'(64'd128 + q_mul_shift(s, 64'd255, 61, 1'b0));
        return SMP_W'(64'd128 - q_mul_shift(s, 64'd255, 61, 1'b1));
    endfunction

    // Expected result for one index under the current settings
    function automatic sample_result_t expected_sample(input logic [IDX_W-1:0] idx);
        sample_result_t        res;
        logic [31:0]           len;
        logic [31:0]           quo;
        logic [PHASE_BITS-1:0] p;
        logic [31:0]           acc;
        res = '0;
        len = (cur_period < PERIOD_W'(MAX_TABLE)) ? 32'(cur_period) : 32'(MAX_TABLE);
        len = len & ~32'd1;   // table length is always even
        if (len == 0 || 32'(idx) >= len)
            return res;
        // phase fraction rounds down; offset may push it below zero, so wrap
        quo = (32'(idx) << PHASE_BITS) / len;
        p   = PHASE_BITS'(quo - 32'(cur_offset));
        case (cur_shape)
            SHAPE_SINE:   res.sample = sine_level(p);
            SHAPE_SQUARE: res.sample = (p > PH_HALF) ? 8'd255 : 8'd0;
            SHAPE_TRIANGLE: begin
                if (p <= PH_HALF)
                    acc = (32'd255 * 32'(p) + 32'(PH_QUARTER)) / 32'(PH_HALF);
                else
                    acc = (32'd255 * ((32'd1 << PHASE_BITS) - 32'(p)) + 32'(PH_QUARTER))
                          / 32'(PH_HALF);
                res.sample = SMP_W'(acc);
            end
            default: begin
                acc        = (32'd255 * 32'(p) + 32'(PH_HALF)) >> PHASE_BITS;
                res.sample = SMP_W'(acc);
            end
        endcase
        res.last = (32'(idx) == len - 1);
        res.ok   = 1'b1;
        return res;
    endfunction

    function automatic int table_len();
        int len;
        len = (cur_period < PERIOD_W'(MAX_TABLE)) ? int'(cur_period) : MAX_TABLE;
        return len & ~1;
    endfunction

    // ------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------

    // Present one index; called at a falling edge, returns at a falling edge with
    // s_valid still high so back-to-back items need no gap.
    task automatic send_index(input logic [IDX_W-1:0] idx);
        while (!src_steady && $urandom_range(99) < 9) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_index = idx;
        do
            @(posedge aclk);
        while (!s_ready);
        pending_samples.push_back(expected_sample(idx));
        items_sent++;
        @(negedge aclk);
    endtask

    // Wait until every expected item has come out, then let the pipe settle
    task automatic drain_results();
        s_valid = 1'b0;
        while (pending_samples.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYC) @(negedge aclk);
    endtask

    // Settings write; only called with the block idle
    task automatic write_setting(input logic [CFG_IDX_W-1:0] reg_idx,
                                 input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   = 1'b1;
        cfg_wr_idx  = reg_idx;
        cfg_wr_data = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (reg_idx)
            REG_WAVE_SHAPE:   cur_shape  = shape_t'(data[SHAPE_W-1:0]);
            REG_PERIOD_US:    cur_period = data[PERIOD_W-1:0];
            REG_PHASE_OFFSET: cur_offset = data[OFFSET_W-1:0];
            default: ;
        endcase
        settings_written++;
    endtask

    task automatic apply_settings(input shape_t shape, input logic [PERIOD_W-1:0] period,
                                  input logic [OFFSET_W-1:0] offset);
        drain_results();
        write_setting(REG_WAVE_SHAPE, CFG_DATA_W'(shape));
        write_setting(REG_PERIOD_US, CFG_DATA_W'(period));
        write_setting(REG_PHASE_OFFSET, CFG_DATA_W'(offset));
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready, with an occasional long stall counted here
    // ------------------------------------------------------------------
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready  = 1'b0;
                repeat (HOLD_CYC) @(negedge aclk);
            end
            m_ready = sink_steady || ($urandom_range(99) >= 9);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted item against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        sample_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_samples.size() == 0) begin
                errors++;
                $display("%0t: unexpected item sample=%0d last=%0b valid_res=%0b",
                         $time, m_sample, m_last, m_valid_res);
            end else begin
                exp_res = pending_samples.pop_front();
                if (m_valid_res) valid_seen++;
                if (m_last) last_seen++;
                if (m_sample !== exp_res.sample) begin
                    errors++;
                    $display("%0t: sample mismatch expected %0d actual %0d",
                             $time, exp_res.sample, m_sample);
                end
                if (m_last !== exp_res.last) begin
                    errors++;
                    $display("%0t: last mismatch expected %0b actual %0b",
                             $time, exp_res.last, m_last);
                end
                if (m_valid_res !== exp_res.ok) begin
                    errors++;
                    $display("%0t: valid_res mismatch expected %0b actual %0b",
                             $time, exp_res.ok, m_valid_res);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Settings straight out of reset: sine, 512-entry table, no offset
    task automatic test_reset_settings();
        send_index(9'd0);
        send_index(9'd1);
        send_index(9'd128);
        send_index(9'd256);
        send_index(9'd384);
        send_index(9'd511);
    endtask

    // Square, triangle and sawtooth around the half and quarter turn
    task automatic test_each_shape();
        apply_settings(SHAPE_SQUARE, 20'd512, 16'd0);
        send_index(9'd256);   // exactly half a turn stays low
        send_index(9'd257);
        send_index(9'd0);
        apply_settings(SHAPE_TRIANGLE, 20'd512, 16'd0);
        send_index(9'd128);
        send_index(9'd256);
        send_index(9'd384);
        apply_settings(SHAPE_SAW, 20'd512, 16'd0);
        send_index(9'd0);
        send_index(9'd255);
        send_index(9'd511);
    endtask

    // Zero length, index past the end, odd period, offset wrap
    task automatic test_edge_cases();
        apply_settings(SHAPE_SINE, 20'd0, 16'd0);
        send_index(9'd0);
        apply_settings(SHAPE_SINE, 20'd1, 16'd0);
        send_index(9'd0);
        apply_settings(SHAPE_SAW, 20'd101, 16'd0);   // odd period: table of 100
        send_index(9'd99);    // final entry
        send_index(9'd100);   // one past the end
        send_index(9'd511);
        apply_settings(SHAPE_SAW, 20'd1000000, 16'hFFFF);
        send_index(9'd0);     // negative phase wraps
        send_index(9'd511);
        apply_settings(SHAPE_SINE, 20'd3, 16'd0);    // period 3: table of 2, index 1 is half a turn
        send_index(9'd1);
    endtask

    // Receiver stalls long while the sender keeps offering: the pipe fills
    task automatic test_output_stall();
        apply_settings(SHAPE_TRIANGLE, 20'd512, 16'd1234);
        src_steady = 1'b1;
        hold_req   = 1'b1;
        for (int i = 0; i < 80; i++)
            send_index(IDX_W'($urandom));
        src_steady = 1'b0;
    endtask

    // Random settings per phase, mostly in-table indices, some noise
    task automatic test_random_traffic();
        logic [PERIOD_W-1:0] period;
        logic [OFFSET_W-1:0] offset;
        shape_t              shape;
        int                  len;
        int                  roll;
        logic [IDX_W-1:0]    idx;
        for (int ph = 0; ph < PHASE_N; ph++) begin
            shape = shape_t'($urandom_range(3));
            case ($urandom_range(11))
                0:       period = 20'd0;
                1:       period = 20'd1;
                2:       period = 20'd2;
                3:       period = 20'd3;
                4:       period = 20'd512;
                5:       period = 20'd513;
                6:       period = 20'd1000000;
                7:       period = 20'hFFFFF;
                default: period = PERIOD_W'($urandom_range(4, 600));
            endcase
            case ($urandom_range(5))
                0:       offset = 16'd0;
                1:       offset = 16'hFFFF;
                2:       offset = 16'h8000;
                default: offset = OFFSET_W'($urandom);
            endcase
            apply_settings(shape, period, offset);
            // one phase runs with neither side idling
            src_steady  = (ph == PHASE_N / 2);
            sink_steady = (ph == PHASE_N / 2);
            len = table_len();
            for (int i = 0; i < PHASE_LEN; i++) begin
                roll = $urandom_range(19);
                if (len > 0 && roll < 16)
                    idx = IDX_W'($urandom_range(len - 1));
                else if (len > 0 && roll < 18)
                    idx = IDX_W'(len - 1);
                else
                    idx = IDX_W'($urandom);
                send_index(idx);
            end
            src_steady  = 1'b0;
            sink_steady = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_idx       = REG_WAVE_SHAPE;
        cfg_wr_data      = '0;
        s_valid          = 1'b0;
        s_index          = '0;
        src_steady       = 1'b0;
        sink_steady      = 1'b0;
        hold_req         = 1'b0;
        errors           = 0;
        items_sent       = 0;
        results_seen     = 0;
        valid_seen       = 0;
        last_seen        = 0;
        settings_written = 0;
        cur_shape        = SHAPE_SINE;
        cur_period       = PERIOD_RESET;
        cur_offset       = '0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_settings();
        test_each_shape();
        test_edge_cases();
        test_output_stall();
        test_random_traffic();
        drain_results();

        $display("Covered %0d items, %0d results (%0d in-table, %0d final-entry) over %0d writes,",
                 items_sent, results_seen, valid_seen, last_seen, settings_written);
        $display("all four shapes, zero and odd table lengths, offset wrap and a long stall.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Run limit, far beyond the slowest expected run
    initial begin
        #2_000_000;
        $display("Timeout with %0d items still expected", pending_samples.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
